[rtl/swft_pkg.sv]
// Shared types and constants for the sorted word frequency table.
// Holds the controller states, the command and status structs, the field widths and the character constants.
// Depends on nothing.
package swft_pkg;

  localparam int TABLE_ENTRIES_DEF  = 1024;
  localparam int TIME_BINS_DEF      = 24;
  localparam int MAX_WORD_CHARS_DEF = 15;

  localparam int WORD_W      = 120;
  localparam int CHAR_SLOTS  = 15;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 184;
  localparam int COUNT_W     = 32;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SRCH,
    S_SCMP,
    S_HCMP,
    S_SHIFT,
    S_MVWR,
    S_INS,
    S_RDCAP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic srch_init;
    logic rd_mid;
    logic srch_step;
    logic rd_p;
    logic hit_upd;
    logic set_full;
    logic shift_init;
    logic mv_rd;
    logic mv_wr;
    logic ins_wr;
    logic rd_idx;
    logic rd_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic word_ok;
    logic search_done;
    logic hit;
    logic full;
    logic dst_at_p;
    logic bin_last;
    logic out_free;
  } status_t;

endpackage

[rtl/sorted_word_frequency_table.sv]
// Top level of the sorted word frequency table: joins controller and datapath.
// Depends on swft_pkg, swft_ctrl and swft_datapath.
//
// Counts words of up to fifteen letters per time bin in a table kept in sorted
// order, and reads entries back by index. One item is worked on at a time; the
// next item is taken while the previous result still waits in the output
// register. The time to count a known word grows with the logarithm of the
// number of words held, set by the binary search through the single read port
// of the word memory. A new word first moves every entry behind it up by one
// place, each stored count read and then written back through the count memory
// one at a time, and then writes its own bins. The stores need no clearing after
// reset.
module sorted_word_frequency_table #(
  parameter int TABLE_ENTRIES  = swft_pkg::TABLE_ENTRIES_DEF,
  parameter int TIME_BINS      = swft_pkg::TIME_BINS_DEF,
  parameter int MAX_WORD_CHARS = swft_pkg::MAX_WORD_CHARS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // word_hi[63:0], word_lo[119:64], word_length[124:120], time_bin[129:125],
  // entry_index[139:130], zero fill.
  input  logic [swft_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // op[0].
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // accepted[0], was_found[1], position[12:2], bin_count[44:13], table_full[45],
  // entry_word_hi[109:46], entry_word_lo[165:110], entry_total[176:166], zero fill.
  output logic [swft_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import swft_pkg::*;

  cmd_t    cmd;
  status_t status;

  swft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .status_i   (status),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  swft_datapath #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .TIME_BINS      (TIME_BINS),
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tready_i (m_axis_tready_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

[rtl/swft_datapath.sv]
// Datapath of the sorted word frequency table: word folding, search registers,
// the word and count memories and the output register. Depends on swft_pkg.
module swft_datapath #(
  parameter int TABLE_ENTRIES  = swft_pkg::TABLE_ENTRIES_DEF,
  parameter int TIME_BINS      = swft_pkg::TIME_BINS_DEF,
  parameter int MAX_WORD_CHARS = swft_pkg::MAX_WORD_CHARS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [swft_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  logic                               s_tuser_i,
  input  logic                               m_tready_i,
  input  swft_pkg::cmd_t                     cmd_i,
  output swft_pkg::status_t                  status_o,
  output logic                               m_tvalid_o,
  output logic [swft_pkg::OUT_TDATA_W-1:0]   m_tdata_o
);
  import swft_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CELLS = TABLE_ENTRIES * TIME_BINS;
  localparam int CA_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int BC_W  = (TIME_BINS > 1) ? $clog2(TIME_BINS) : 1;

  logic [WORD_W-1:0]  word_in;
  logic [4:0]         len_in;
  logic [4:0]         bin_in;
  logic [9:0]         idx_in;
  logic [WORD_W-1:0]  fold_word;
  logic               fold_ok;
  logic [7:0]         ch_c;
  logic [7:0]         low_c;

  logic               op_q;
  logic [WORD_W-1:0]  word_q;
  logic               ok_q;
  logic [4:0]         bin_q;
  logic               bin_ok_q;
  logic [9:0]         idx_q;
  logic [CNT_W-1:0]   left_q, right_q, used_q, dst_q;
  logic [BC_W-1:0]    b_q;
  logic [CNT_W-1:0]   mid, dst_m1;

  logic               res_acc_q, res_found_q, res_full_q;
  logic [10:0]        res_pos_q;
  logic [COUNT_W-1:0] res_cnt_q;
  logic [WORD_W-1:0]  res_word_q;
  logic               m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  logic [WORD_W-1:0]  wmem [TABLE_ENTRIES];
  logic [COUNT_W-1:0] cmem [CELLS];
  logic [WORD_W-1:0]  w_rdata_q;
  logic [COUNT_W-1:0] c_rdata_q;

  logic               rd_en, w_we, c_we;
  logic [IDX_W-1:0]   rd_row, w_waddr, wr_row;
  logic [BC_W-1:0]    rd_col, wr_col;
  logic [CA_W-1:0]    c_raddr, c_waddr;
  logic [WORD_W-1:0]  w_wdata;
  logic [COUNT_W-1:0] c_wdata, cnt_inc;
  logic               bin_last;

  assign word_in = {s_tdata_i[63:0], s_tdata_i[119:64]};
  assign len_in  = s_tdata_i[124:120];
  assign bin_in  = s_tdata_i[129:125];
  assign idx_in  = s_tdata_i[139:130];

  always_comb begin
    fold_word = '0;
    fold_ok   = (32'(len_in) <= 32'(MAX_WORD_CHARS));
    ch_c      = '0;
    low_c     = '0;
    for (int k = 0; k < CHAR_SLOTS; k++) begin
      ch_c  = word_in[WORD_W-1-8*k -: 8];
      low_c = ch_c | CASE_BIT;
      if (5'(k) < len_in) begin
        if (!((ch_c >= CH_UPPER_A && ch_c <= CH_UPPER_Z) ||
              (ch_c >= CH_LOWER_A && ch_c <= CH_LOWER_Z))) begin
          fold_ok = 1'b0;
        end
        fold_word[WORD_W-1-8*k -: 8] = low_c;
      end
    end
    if (!fold_ok) begin
      fold_word = '0;
    end
  end

  assign mid      = left_q + ((right_q - left_q) >> 1);
  assign dst_m1   = dst_q - CNT_W'(1);
  assign bin_last = (b_q == BC_W'(TIME_BINS - 1));
  assign cnt_inc  = (c_rdata_q == '1) ? c_rdata_q : c_rdata_q + COUNT_W'(1);

  always_comb begin
    rd_row = IDX_W'(idx_q);
    rd_col = BC_W'(bin_q);
    if (cmd_i.rd_mid) begin
      rd_row = mid[IDX_W-1:0];
    end else if (cmd_i.rd_p) begin
      rd_row = left_q[IDX_W-1:0];
    end else if (cmd_i.mv_rd) begin
      rd_row = dst_m1[IDX_W-1:0];
      rd_col = b_q;
    end
    rd_en   = cmd_i.rd_mid | cmd_i.rd_p | cmd_i.mv_rd | cmd_i.rd_idx;
    c_raddr = CA_W'(rd_row) * CA_W'(TIME_BINS) + CA_W'(rd_col);
  end

  always_comb begin
    wr_row  = left_q[IDX_W-1:0];
    wr_col  = b_q;
    w_wdata = word_q;
    c_wdata = (bin_ok_q && b_q == BC_W'(bin_q)) ? COUNT_W'(1) : '0;
    w_we    = cmd_i.mv_wr | cmd_i.ins_wr;
    c_we    = cmd_i.mv_wr | cmd_i.ins_wr | (cmd_i.hit_upd & bin_ok_q);
    if (cmd_i.hit_upd) begin
      wr_col  = BC_W'(bin_q);
      c_wdata = cnt_inc;
    end else if (cmd_i.mv_wr) begin
      wr_row  = dst_q[IDX_W-1:0];
      w_wdata = w_rdata_q;
      c_wdata = c_rdata_q;
    end
    w_waddr = wr_row;
    c_waddr = CA_W'(wr_row) * CA_W'(TIME_BINS) + CA_W'(wr_col);
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    if (rd_en) begin
      w_rdata_q <= wmem[rd_row];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    if (rd_en) begin
      c_rdata_q <= cmem[c_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ins_wr && bin_last) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= s_tuser_i;
      word_q      <= fold_word;
      ok_q        <= fold_ok;
      bin_q       <= bin_in;
      bin_ok_q    <= (32'(bin_in) < 32'(TIME_BINS));
      idx_q       <= idx_in;
      res_acc_q   <= 1'b0;
      res_found_q <= 1'b0;
      res_full_q  <= 1'b0;
      res_pos_q   <= s_tuser_i ? 11'(idx_in) : '0;
      res_cnt_q   <= '0;
      res_word_q  <= '0;
    end
    if (cmd_i.srch_init) begin
      left_q  <= '0;
      right_q <= used_q;
    end
    if (cmd_i.srch_step) begin
      if (w_rdata_q < word_q) begin
        left_q <= mid + CNT_W'(1);
      end else begin
        right_q <= mid;
      end
    end
    if (cmd_i.hit_upd) begin
      res_acc_q   <= 1'b1;
      res_found_q <= 1'b1;
      res_pos_q   <= 11'(left_q);
      res_word_q  <= word_q;
      if (bin_ok_q) begin
        res_cnt_q <= cnt_inc;
      end
    end
    if (cmd_i.set_full) begin
      res_acc_q  <= 1'b1;
      res_full_q <= 1'b1;
      res_pos_q  <= 11'(left_q);
      res_word_q <= word_q;
    end
    if (cmd_i.shift_init) begin
      dst_q <= used_q;
      b_q   <= '0;
    end
    if (cmd_i.mv_wr) begin
      if (bin_last) begin
        b_q   <= '0;
        dst_q <= dst_m1;
      end else begin
        b_q <= b_q + BC_W'(1);
      end
    end
    if (cmd_i.ins_wr) begin
      b_q <= bin_last ? '0 : b_q + BC_W'(1);
      if (bin_last) begin
        res_acc_q  <= 1'b1;
        res_pos_q  <= 11'(left_q);
        res_word_q <= word_q;
        res_cnt_q  <= COUNT_W'(bin_ok_q);
      end
    end
    if (cmd_i.rd_cap && (32'(idx_q) < 32'(used_q))) begin
      res_found_q <= 1'b1;
      res_word_q  <= w_rdata_q;
      res_cnt_q   <= bin_ok_q ? c_rdata_q : '0;
    end
    if (cmd_i.out_load) begin
      m_data_q <= {7'd0, 11'(used_q), res_word_q[55:0], res_word_q[119:56], res_full_q,
                   res_cnt_q, res_pos_q, res_found_q, res_acc_q};
    end
  end

  always_comb begin
    status_o.op          = op_q;
    status_o.word_ok     = ok_q;
    status_o.search_done = (left_q == right_q);
    status_o.hit         = (left_q < used_q) && (w_rdata_q == word_q);
    status_o.full        = (used_q == CNT_W'(TABLE_ENTRIES));
    status_o.dst_at_p    = (dst_q == left_q);
    status_o.bin_last    = bin_last;
    status_o.out_free    = !m_valid_q || m_tready_i;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

[rtl/swft_ctrl.sv]
// Controller state machine of the sorted word frequency table.
// Sequences search, update, shift, insert and read steps. Depends on swft_pkg.
module swft_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  swft_pkg::status_t status_i,
  output logic              s_tready_o,
  output swft_pkg::cmd_t    cmd_o
);
  import swft_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.op) state_d = S_RDCAP;
        else if (!status_i.word_ok) state_d = S_OUT;
        else state_d = S_SRCH;
      end
      S_SRCH: begin
        state_d = status_i.search_done ? S_HCMP : S_SCMP;
      end
      S_SCMP: state_d = S_SRCH;
      S_HCMP: begin
        if (status_i.hit || status_i.full) state_d = S_OUT;
        else state_d = S_SHIFT;
      end
      S_SHIFT: begin
        state_d = status_i.dst_at_p ? S_INS : S_MVWR;
      end
      S_MVWR: state_d = S_SHIFT;
      S_INS: begin
        if (status_i.bin_last) state_d = S_OUT;
      end
      S_RDCAP: state_d = S_OUT;
      S_OUT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      S_DECIDE: begin
        cmd_o.rd_idx    = status_i.op;
        cmd_o.srch_init = !status_i.op && status_i.word_ok;
      end
      S_SRCH: begin
        cmd_o.rd_mid = !status_i.search_done;
        cmd_o.rd_p   = status_i.search_done;
      end
      S_SCMP: cmd_o.srch_step = 1'b1;
      S_HCMP: begin
        cmd_o.hit_upd    = status_i.hit;
        cmd_o.set_full   = !status_i.hit && status_i.full;
        cmd_o.shift_init = !status_i.hit && !status_i.full;
      end
      S_SHIFT: cmd_o.mv_rd = !status_i.dst_at_p;
      S_MVWR:  cmd_o.mv_wr = 1'b1;
      S_INS:   cmd_o.ins_wr = 1'b1;
      S_RDCAP: cmd_o.rd_cap = 1'b1;
      S_OUT:   cmd_o.out_load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/swft_checker.sv]
// Port-level checks for the sorted word frequency table, bound to the top level.
// Depends on swft_pkg and sorted_word_frequency_table.
module swft_checker #(
  parameter int TABLE_ENTRIES = swft_pkg::TABLE_ENTRIES_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [swft_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result item changed or vanished.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("Input taken again right after an item was accepted.");

  a_full_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[45] |->
      m_axis_tdata_o[0] && !m_axis_tdata_o[1] && (m_axis_tdata_o[44:13] == 32'd0) &&
      (m_axis_tdata_o[176:166] == 11'(TABLE_ENTRIES)))
    else $error("Full flag raised on an inconsistent result.");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> 32'(m_axis_tdata_o[176:166]) <= 32'(TABLE_ENTRIES))
    else $error("Entry total exceeds the table size.");

endmodule

bind sorted_word_frequency_table swft_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (.*);
